// ===== rtl/crystal_temp_trim_assert.svh =====
// assertion macros shared by the crystal trim rtl
`ifndef CRYSTAL_TEMP_TRIM_ASSERT_SVH
`define CRYSTAL_TEMP_TRIM_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CTT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crystal_temp_trim assertion failed");

// next-cycle implication, checked outside reset
`define CTT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crystal_temp_trim assertion failed");

`endif

// ===== rtl/ctt_pkg.sv =====
// types and constants of the crystal temperature trim block
package ctt_pkg;

    // stream and config port widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CRYSTAL_ERROR = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURNOVER_TEMP = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_ABOVE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BELOW    = 8'd3;

    // register reset values
    localparam logic [15:0] CRYSTAL_ERROR_RST = 16'sd0;
    localparam logic [11:0] TURNOVER_TEMP_RST = 12'sd252;
    localparam logic [15:0] COEF_RST          = -16'sd320;

    // arithmetic constants
    localparam logic [13:0] PD_OFFSET      = 14'd15;
    localparam logic [13:0] DRIFT_SCALE    = 14'd10000;
    localparam logic [15:0] DRIFT_LIMIT    = 16'd26000;
    // product below scale * (limit + 1) gives a drift within the limit
    localparam logic [41:0] PROD_LIMIT     = 42'd260010000;

    // last iteration indexes of the serial units
    localparam logic [4:0] MUL_LAST  = 5'd15;
    localparam logic [4:0] DIVD_LAST = 5'd27;
    localparam logic [4:0] DIVT_LAST = 5'd15;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SQR  = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIVD = 7'b0001000,
        ST_SUM  = 7'b0010000,
        ST_DIVT = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

endpackage

// ===== rtl/crystal_temp_trim.sv =====
// crystal temperature trim: parabolic drift, error sum and trim step division
// one sample at a time: a new input beat is taken only in the idle state; each runs
// through the bit-serial shift-add multiplier (2 x 16 steps) and the shared restoring
//   divider (28 + 16 steps), and an out-of-range drift skips the drift division
// an input beat is taken while the previous result still waits in the output register
// reset (rst_n low, async): registers to defaults, held drift and remainder to zero
`include "crystal_temp_trim_assert.svh"

module crystal_temp_trim #(
    parameter int TRIM_STEP = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ctt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // temperature[11:0], zero pad
    input  logic [ctt_pkg::IN_TUSER_W-1:0]      s_axis_tuser,  // power_down[0]
    // output stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ctt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // trim_value[16:0],
                                                               // total_ppm[33:17],
                                                               // drift_ppm[49:34], zero pad
    output logic [ctt_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,  // mode_out[0]
    // register write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ctt_pkg::*;

    // trim step as divisor, fits the divider remainder width
    localparam logic [13:0] STEP_DIV = 14'(TRIM_STEP);

    // configuration registers
    logic [15:0] crystal_error_reg;
    logic [11:0] turnover_temp_reg;
    logic [15:0] coef_above_reg;
    logic [15:0] coef_below_reg;

    // block state
    logic [15:0] held_drift_reg, held_drift_next;
    logic [15:0] carry_rem_reg, carry_rem_next;

    // control
    state_t      state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    // datapath
    logic [41:0] prod_reg, prod_next;     // product, multiplier shifts out at the bottom
    logic [25:0] mcand_reg, mcand_next;
    logic [15:0] coef_mag_reg, coef_mag_next;
    logic        coef_neg_reg, coef_neg_next;
    logic        mode_reg, mode_next;
    logic [27:0] quo_reg, quo_next;       // dividend shifts out on top, quotient in below
    logic [13:0] rem_reg, rem_next;
    logic [16:0] sum_reg, sum_next;
    logic [16:0] out_trim_reg, out_trim_next;
    logic [16:0] out_total_reg, out_total_next;
    logic [15:0] out_drift_reg, out_drift_next;
    logic        out_mode_reg, out_mode_next;

    // input decode
    logic [13:0] temp_adj;
    logic [13:0] diff;
    logic [12:0] diff_mag;
    logic [15:0] coef_sel;

    // serial unit steps
    logic [26:0] add_sum;
    logic [41:0] mul_step;
    logic [14:0] trial;
    logic        fits;
    logic [13:0] divisor;
    logic [13:0] rem_step;
    logic [27:0] quo_step;
    logic        cnt_last;

    // sum and result shaping
    logic [16:0] total;
    logic [16:0] total_mag;
    logic [15:0] drift_mag;
    logic [16:0] trim_mag;
    logic        in_fire;
    logic        out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_drift_reg, out_total_reg, out_trim_reg};
    assign m_axis_tuser  = out_mode_reg;

    // sample plus power-down offset, distance from turnover
    always_comb
    begin
        temp_adj = {{2{s_axis_tdata[11]}}, s_axis_tdata[11:0]}
                 + (s_axis_tuser[0] ? PD_OFFSET : 14'd0);
        diff     = temp_adj - {{2{turnover_temp_reg[11]}}, turnover_temp_reg};
        diff_mag = diff[13] ? 13'(-diff) : diff[12:0];
        coef_sel = diff[13] ? coef_below_reg : coef_above_reg;
    end

    // one shift-add step: add multiplicand on the multiplier lsb, shift right
    always_comb
    begin
        add_sum  = {1'b0, prod_reg[41:16]} + (prod_reg[0] ? {1'b0, mcand_reg} : 27'd0);
        mul_step = {add_sum, prod_reg[15:1]};
    end

    // one restoring division step, msb first
    always_comb
    begin
        divisor  = (state_reg == ST_DIVD) ? DRIFT_SCALE : STEP_DIV;
        trial    = {rem_reg, quo_reg[27]};
        fits     = (trial >= {1'b0, divisor});
        rem_step = fits ? 14'(trial - {1'b0, divisor}) : trial[13:0];
        quo_step = {quo_reg[26:0], fits};
    end

    always_comb
    begin
        unique case (state_reg)
            ST_SQR, ST_MUL: cnt_last = (cnt_reg == MUL_LAST);
            ST_DIVD:        cnt_last = (cnt_reg == DIVD_LAST);
            ST_DIVT:        cnt_last = (cnt_reg == DIVT_LAST);
            default:        cnt_last = 1'b0;
        endcase
    end

    always_comb
    begin
        total     = {crystal_error_reg[15], crystal_error_reg}
                  + {held_drift_reg[15], held_drift_reg}
                  + {carry_rem_reg[15], carry_rem_reg};
        total_mag = total[16] ? -total : total;
        drift_mag = {1'b0, quo_step[14:0]};
        trim_mag  = {1'b0, quo_reg[15:0]};
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        held_drift_next = held_drift_reg;
        carry_rem_next  = carry_rem_reg;
        prod_next       = prod_reg;
        mcand_next      = mcand_reg;
        coef_mag_next   = coef_mag_reg;
        coef_neg_next   = coef_neg_reg;
        mode_next       = mode_reg;
        quo_next        = quo_reg;
        rem_next        = rem_reg;
        sum_next        = sum_reg;
        out_trim_next   = out_trim_reg;
        out_total_next  = out_total_reg;
        out_drift_next  = out_drift_reg;
        out_mode_next   = out_mode_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    // square the distance first: multiplicand and multiplier both |diff|
                    prod_next     = {26'd0, 3'd0, diff_mag};
                    mcand_next    = {13'd0, diff_mag};
                    coef_neg_next = coef_sel[15];
                    coef_mag_next = coef_sel[15] ? 16'(-coef_sel) : coef_sel;
                    mode_next     = s_axis_tuser[0];
                    cnt_next      = '0;
                    state_next    = ST_SQR;
                end
            end
            ST_SQR:
            begin
                prod_next = mul_step;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_last)
                begin
                    // square becomes the multiplicand, coefficient magnitude the multiplier
                    mcand_next = mul_step[25:0];
                    prod_next  = {26'd0, coef_mag_reg};
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next = mul_step;
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_last)
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    quo_next = mul_step[27:0];
                    // out-of-range drift keeps the held value, skip the division
                    state_next = (mul_step < PROD_LIMIT) ? ST_DIVD : ST_SUM;
                end
            end
            ST_DIVD:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_last)
                begin
                    held_drift_next = coef_neg_reg ? 16'(-drift_mag) : drift_mag;
                    state_next      = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next   = total;
                quo_next   = {total_mag[15:0], 12'd0};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIVT;
            end
            ST_DIVT:
            begin
                quo_next = quo_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand the result over once the output register is free
                if (out_free)
                begin
                    out_trim_next  = sum_reg[16] ? -trim_mag : trim_mag;
                    out_total_next = sum_reg;
                    out_drift_next = held_drift_reg;
                    out_mode_next  = mode_reg;
                    out_valid_next = 1'b1;
                    carry_rem_next = sum_reg[16] ? -{2'b0, rem_reg} : {2'b0, rem_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control, configuration and carried state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            out_valid_reg     <= 1'b0;
            held_drift_reg    <= '0;
            carry_rem_reg     <= '0;
            crystal_error_reg <= CRYSTAL_ERROR_RST;
            turnover_temp_reg <= TURNOVER_TEMP_RST;
            coef_above_reg    <= COEF_RST;
            coef_below_reg    <= COEF_RST;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            held_drift_reg <= held_drift_next;
            carry_rem_reg  <= carry_rem_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_CRYSTAL_ERROR: crystal_error_reg <= cfg_data;
                    REG_TURNOVER_TEMP: turnover_temp_reg <= cfg_data[11:0];
                    REG_COEF_ABOVE:    coef_above_reg    <= cfg_data;
                    REG_COEF_BELOW:    coef_below_reg    <= cfg_data;
                    default:           ;  // unmapped index, write dropped
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        mcand_reg     <= mcand_next;
        coef_mag_reg  <= coef_mag_next;
        coef_neg_reg  <= coef_neg_next;
        mode_reg      <= mode_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        sum_reg       <= sum_next;
        out_trim_reg  <= out_trim_next;
        out_total_reg <= out_total_next;
        out_drift_reg <= out_drift_next;
        out_mode_reg  <= out_mode_next;
    end

    // held drift never leaves the accepted band
    `CTT_ASSERT_IMP(a_held_band, clk, rst_n, 1'b1,
        ($signed(held_drift_reg) <= $signed(DRIFT_LIMIT)) &&
        ($signed(held_drift_reg) >= -$signed(DRIFT_LIMIT)))

    // carried remainder stays below one trim step in magnitude
    `CTT_ASSERT_IMP(a_carry_band, clk, rst_n, 1'b1,
        ($signed({carry_rem_reg[15], carry_rem_reg}) < $signed({3'b0, STEP_DIV})) &&
        ($signed({carry_rem_reg[15], carry_rem_reg}) > -$signed({3'b0, STEP_DIV})))

    // partial remainder is always reduced below the divisor
    `CTT_ASSERT_IMP(a_rem_reduced, clk, rst_n,
        (state_reg == ST_DIVD) || (state_reg == ST_DIVT), rem_reg < divisor)

    // a new result appears only out of the final state
    `CTT_ASSERT_IMP(a_out_from_done, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg) == ST_DONE)

endmodule

// ===== dv/crystal_temp_trim_tb.sv =====
// self-checking testbench of crystal_temp_trim: directed and random temperature samples
module crystal_temp_trim_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ctt_pkg::*;

    // trim step of the block under test and the arithmetic of the drift law
    localparam int     STEP_SIZE     = 24;
    localparam longint DRIFT_DIV     = 10000;
    localparam longint DRIFT_MAX     = 26000;
    localparam longint PD_RAISE      = 15;
    // run control
    localparam int     RESET_CYCLES  = 7;
    localparam int     SETTLE_CYCLES = 100;   // wait before the final check for beats still owed
    localparam longint CYCLE_LIMIT   = 500000;

    // one temperature sample as it travels on the input stream
    typedef struct packed {
        logic [11:0] temp;
        logic        pd;
    } sample_t;

    // one trim beat as it leaves the block
    typedef struct packed {
        logic [16:0] trim;
        logic [16:0] total;
        logic [15:0] drift;
        logic        mode;
    } trim_beat_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // temperature[11:0], zero pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;   // power_down[0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // trim[16:0], total[33:17], drift[49:34]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;         // mode_out[0]
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // samples waiting for the source driver, and trim beats still owed by the block
    sample_t    sample_q[$];
    trim_beat_t trim_q[$];

    // register copies and the carried state of the compensation loop
    longint err_reg;
    longint turn_reg;
    longint coef_hi_reg;
    longint coef_lo_reg;
    longint drift_held;
    longint carry_rem;

    // idling control, percent chance per free slot of starting a burst
    int src_gap_pct   = 0;
    int snk_stall_pct = 0;
    int src_gap       = 0;
    int snk_stall     = 0;

    logic   in_fire        = 1'b0;
    longint cycles         = 0;
    int     errors         = 0;
    int     items_queued   = 0;
    int     samples_taken  = 0;
    int     beats_checked  = 0;
    int     drifts_dropped = 0;
    int     pd_samples     = 0;
    int     reg_writes     = 0;
    int     settings       = 0;

    crystal_temp_trim #(
        .TRIM_STEP(STEP_SIZE)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // parabolic drift, error sum and trim division for one sample; advances the loop state
    function automatic trim_beat_t compensate(input sample_t smp);
        logic signed [11:0] ts;
        longint             t;
        longint             coef;
        longint             diff;
        longint             drift;
        longint             sum;
        longint             quo;
        trim_beat_t         res;
        ts = smp.temp;
        t  = ts;
        if (smp.pd)
        begin
            t = t + PD_RAISE;
        end
        // the high coefficient applies at the turnover point itself
        coef  = (t >= turn_reg) ? coef_hi_reg : coef_lo_reg;
        diff  = t - turn_reg;
        drift = (diff * diff * coef) / DRIFT_DIV;
        // a drift beyond the limit is dropped and the previous one is reused
        if (drift >= -DRIFT_MAX && drift <= DRIFT_MAX)
        begin
            drift_held = drift;
        end
        else
        begin
            drifts_dropped++;
        end
        sum       = err_reg + drift_held + carry_rem;
        quo       = sum / STEP_SIZE;
        carry_rem = sum - quo * STEP_SIZE;
        res.trim  = quo[16:0];
        res.total = sum[16:0];
        res.drift = drift_held[15:0];
        res.mode  = smp.pd;
        return res;
    endfunction

    task automatic check_field(input string what, input longint want, input longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // monitor: checks trim beats, and predicts each accepted sample
    always @(posedge clk)
    begin : beat_monitor
        trim_beat_t want;
        sample_t    smp;
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d beats still owed", cycles, trim_q.size());
            $display("FAILED: results differ");
            $finish;
        end
        else if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (trim_q.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: unexpected trim beat, tdata %h", $time, m_axis_tdata);
                end
                else
                begin
                    want = trim_q.pop_front();
                    beats_checked++;
                    check_field("trim_value", $signed(want.trim), $signed(m_axis_tdata[16:0]));
                    check_field("total_ppm", $signed(want.total), $signed(m_axis_tdata[33:17]));
                    check_field("drift_ppm", $signed(want.drift), $signed(m_axis_tdata[49:34]));
                    check_field("mode_out", want.mode, m_axis_tuser[0]);
                end
            end
            // the driver reads this at the next falling edge to free its slot
            in_fire = s_axis_tvalid && s_axis_tready;
            if (in_fire)
            begin
                smp.temp = s_axis_tdata[11:0];
                smp.pd   = s_axis_tuser[0];
                samples_taken++;
                if (smp.pd)
                begin
                    pd_samples++;
                end
                trim_q.push_back(compensate(smp));
            end
        end
    end

    // source driver: one sample per free slot, with random gap bursts
    always @(negedge clk)
    begin : sample_driver
        sample_t nxt;
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (sample_q.size() != 0 && src_gap_pct != 0
                     && $urandom_range(0, 99) < src_gap_pct)
            begin
                // this slot is the first idle cycle of the burst
                src_gap = $urandom_range(1, 17) - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (sample_q.size() != 0)
            begin
                nxt = sample_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_TDATA_W'(nxt.temp);
                s_axis_tuser  <= nxt.pd;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink: ready with random stall bursts
    always @(negedge clk)
    begin : trim_sink
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (snk_stall > 0)
        begin
            snk_stall--;
            m_axis_tready <= 1'b0;
        end
        else if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct)
        begin
            snk_stall = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // register write; indexes beyond the four registers leave the copies alone
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        logic signed [15:0] v16;
        logic signed [11:0] v12;
        v16 = val;
        v12 = val[11:0];
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_CRYSTAL_ERROR: err_reg     = v16;
            REG_TURNOVER_TEMP: turn_reg    = v12;
            REG_COEF_ABOVE:    coef_hi_reg = v16;
            REG_COEF_BELOW:    coef_lo_reg = v16;
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_regs(input logic [15:0] err, input logic [15:0] turn,
                            input logic [15:0] c_hi, input logic [15:0] c_lo);
        write_reg(REG_CRYSTAL_ERROR, err);
        write_reg(REG_TURNOVER_TEMP, turn);
        write_reg(REG_COEF_ABOVE, c_hi);
        write_reg(REG_COEF_BELOW, c_lo);
        settings++;
    endtask

    task automatic queue_sample(input logic [11:0] temp, input logic pd);
        sample_t s;
        s.temp = temp;
        s.pd   = pd;
        sample_q.push_back(s);
        items_queued++;
    endtask

    // hold off until every sample is taken and every trim beat has come back
    task automatic drain();
        while (samples_taken != items_queued || trim_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // mostly around turnover so the drift stays in range, some anywhere in 12 bits, the rest in -1000..1500
    function automatic logic [11:0] pick_temp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
        begin
            return 12'($urandom_range(0, 4095));
        end
        else if (sel < 8)
        begin
            return 12'(turn_reg + int'($urandom_range(0, 400)) - 200);
        end
        return 12'(int'($urandom_range(0, 2500)) - 1000);
    endfunction

    function automatic logic [15:0] pick_coef();
        if ($urandom_range(0, 3) == 0)
        begin
            return 16'($urandom);
        end
        return 16'(int'($urandom_range(0, 1000)) - 500);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 10;
            default: return 40;
        endcase
    endfunction

    // one batch of random samples at the given idling, then wait for all beats
    task automatic run_phase(input int count, input int src_pct, input int snk_pct);
        src_gap_pct   = src_pct;
        snk_stall_pct = snk_pct;
        @(posedge clk);
        for (int i = 0; i < count; i++)
        begin
            queue_sample(pick_temp(), 1'($urandom_range(0, 1)));
        end
        drain();
    endtask

    initial
    begin
        // copies start at the reset values of the block
        err_reg     = 0;
        turn_reg    = 252;
        coef_hi_reg = -320;
        coef_lo_reg = -320;
        drift_held  = 0;
        carry_rem   = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // writes to indexes past the register file must change nothing
        write_reg(8'd4, 16'($urandom));
        write_reg(8'hff, 16'($urandom));

        // directed part at reset settings: zero, turnover edges (also reached through
        // the power-down offset), 12-bit extremes, stated range ends, and the drift
        // limit crossed on both sides of turnover
        src_gap_pct   = 25;
        snk_stall_pct = 25;
        @(posedge clk);
        queue_sample(12'd0, 1'b0);
        queue_sample(12'd0, 1'b1);
        queue_sample(12'd252, 1'b0);
        queue_sample(12'd251, 1'b0);
        queue_sample(12'd237, 1'b1);
        queue_sample(12'd236, 1'b1);
        queue_sample(12'h7ff, 1'b0);
        queue_sample(12'h7ff, 1'b1);
        queue_sample(12'h800, 1'b0);
        queue_sample(12'h800, 1'b1);
        queue_sample(12'd1500, 1'b0);
        queue_sample(12'd1500, 1'b1);
        queue_sample(-12'sd1000, 1'b0);
        queue_sample(-12'sd1000, 1'b1);
        queue_sample(12'd1153, 1'b0);
        queue_sample(12'd1154, 1'b0);
        queue_sample(-12'sd649, 1'b0);
        queue_sample(-12'sd650, 1'b0);
        queue_sample(12'd1000, 1'b0);
        queue_sample(12'd500, 1'b1);
        queue_sample(12'hfff, 1'b0);
        drain();
        run_phase(40, 25, 25);

        // register extremes, including the 12-bit ends of the turnover field
        set_regs(16'h7fff, 16'h07ff, 16'h7fff, 16'h8000);
        run_phase(70, 30, 0);
        set_regs(16'h8000, 16'h0800, 16'h8000, 16'h7fff);
        run_phase(70, 0, 30);
        set_regs(16'h0000, 16'(-400), 16'h0000, 16'h0000);
        run_phase(50, 15, 15);
        set_regs(16'h0001, 16'd1250, 16'h0001, 16'hffff);
        run_phase(50, 15, 15);

        // random settings, upper config bits of the turnover write random too
        repeat (5)
        begin
            set_regs($urandom_range(0, 1) ? 16'($urandom) : 16'(int'($urandom_range(0, 2000)) - 1000),
                     {4'($urandom), 12'(int'($urandom_range(0, 1650)) - 400)},
                     pick_coef(), pick_coef());
            run_phase(70, pick_pct(), pick_pct());
        end

        // last stretch runs back to back with no idling on either side
        set_regs(16'($urandom), 16'(int'($urandom_range(0, 1650)) - 400), pick_coef(), pick_coef());
        run_phase(100, 0, 0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (trim_q.size() != 0)
        begin
            errors += trim_q.size();
            $display("%0d trim beats never arrived", trim_q.size());
        end

        $display("run covered %0d samples (%0d in power-down) under %0d register settings",
                 samples_taken, pd_samples, settings + 1);
        $display("%0d trim beats checked, %0d register writes, %0d drifts beyond the limit held",
                 beats_checked, reg_writes, drifts_dropped);
        if (errors == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ctt_pkg.sv
rtl/crystal_temp_trim.sv
dv/crystal_temp_trim_tb.sv
